@@ design/pmc_pkg.sv @@
package pmc_pkg;

	// field widths
	localparam int ACC_W      = 16;
	localparam int RAW_W      = 16;
	localparam int GYR_W      = 17;
	localparam int THR_W      = 16;
	localparam int CNT_W      = 7;
	localparam int POS_W      = 6;
	localparam int ENTRY_W    = 3 * ACC_W + 3 * GYR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// saturation value of the post-trigger counter
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_X        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Y        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET_Z        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_THRESHOLD        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POST_TRIGGER_SAMPLES = 3'd4;

	// configuration reset values
	localparam logic [RAW_W-1:0] GYRO_OFFSET_X_RST        = 16'd478;
	localparam logic [RAW_W-1:0] GYRO_OFFSET_Y_RST        = 16'd100;
	localparam logic [RAW_W-1:0] GYRO_OFFSET_Z_RST        = 16'd20;
	localparam logic [THR_W-1:0] ARM_THRESHOLD_RST        = 16'd8000;
	localparam logic [CNT_W-1:0] POST_TRIGGER_SAMPLES_RST = 7'd45;

	// controller to datapath commands
	typedef struct packed {
		logic sample_we;
		logic rd_en;
		logic load_out;
	} pmc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic emit;
		logic last_out;
	} pmc_sts_t;

endpackage

@@ design/pmc_ram.sv @@
module pmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/pmc_ctrl.sv @@
module pmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  pmc_pkg::pmc_sts_t sts,
	output logic              in_ready,
	output logic              out_valid,
	output pmc_pkg::pmc_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_OUT  = 4'b1000
	} pmc_state_t;

	pmc_state_t state_q;
	pmc_state_t state_d;
	logic       in_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_xfer   = in_valid && in_ready;

	// commands
	always_comb begin
		cmd           = '0;
		cmd.sample_we = in_xfer;
		cmd.rd_en     = (state_q == ST_READ);
		cmd.load_out  = (state_q == ST_LOAD);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && sts.emit) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = sts.last_out ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/pmc_dp.sv @@
module pmc_dp #(
	parameter int DEPTH = 60
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic        [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [pmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  pmc_pkg::pmc_cmd_t                      cmd,
	input  logic signed [pmc_pkg::RAW_W-1:0]       accel_x,
	input  logic signed [pmc_pkg::RAW_W-1:0]       accel_y,
	input  logic signed [pmc_pkg::RAW_W-1:0]       accel_z,
	input  logic signed [pmc_pkg::RAW_W-1:0]       gyro_x,
	input  logic signed [pmc_pkg::RAW_W-1:0]       gyro_y,
	input  logic signed [pmc_pkg::RAW_W-1:0]       gyro_z,
	output pmc_pkg::pmc_sts_t                      sts,
	output logic signed [pmc_pkg::ACC_W-1:0]       win_accel_x,
	output logic signed [pmc_pkg::ACC_W-1:0]       win_accel_y,
	output logic signed [pmc_pkg::ACC_W-1:0]       win_accel_z,
	output logic signed [pmc_pkg::GYR_W-1:0]       win_gyro_x,
	output logic signed [pmc_pkg::GYR_W-1:0]       win_gyro_y,
	output logic signed [pmc_pkg::GYR_W-1:0]       win_gyro_z,
	output logic        [pmc_pkg::POS_W-1:0]       window_position,
	output logic                                   last_of_window
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// configuration registers
	logic [pmc_pkg::RAW_W-1:0] off_x_q;
	logic [pmc_pkg::RAW_W-1:0] off_y_q;
	logic [pmc_pkg::RAW_W-1:0] off_z_q;
	logic [pmc_pkg::THR_W-1:0] thr_q;
	logic [pmc_pkg::CNT_W-1:0] post_q;

	// capture state
	logic [ADDR_W-1:0]         slot_q;
	logic [ADDR_W-1:0]         slot_next;
	logic                      armed_q;
	logic [pmc_pkg::CNT_W-1:0] cnt_q;
	logic [pmc_pkg::CNT_W-1:0] cnt_next;
	logic [DEPTH-1:0]          valid_q;
	logic [ADDR_W-1:0]         rd_ptr_q;
	logic [ADDR_W-1:0]         pos_q;
	logic                      entry_valid_s1;

	// corrected gyro and trigger test
	logic signed [pmc_pkg::GYR_W-1:0] gx;
	logic signed [pmc_pkg::GYR_W-1:0] gy;
	logic signed [pmc_pkg::GYR_W-1:0] gz;
	logic        [pmc_pkg::GYR_W-1:0] mag_x;
	logic        [pmc_pkg::GYR_W-1:0] mag_y;
	logic        [pmc_pkg::GYR_W-1:0] mag_z;
	logic        [pmc_pkg::GYR_W-1:0] thr_ext;
	logic                             trig;

	logic [pmc_pkg::ENTRY_W-1:0] wr_entry;
	logic [pmc_pkg::ENTRY_W-1:0] rd_entry;
	logic [pmc_pkg::ENTRY_W-1:0] out_entry;

	// configuration writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= pmc_pkg::GYRO_OFFSET_X_RST;
			off_y_q <= pmc_pkg::GYRO_OFFSET_Y_RST;
			off_z_q <= pmc_pkg::GYRO_OFFSET_Z_RST;
			thr_q   <= pmc_pkg::ARM_THRESHOLD_RST;
			post_q  <= pmc_pkg::POST_TRIGGER_SAMPLES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pmc_pkg::CFG_GYRO_OFFSET_X:        off_x_q <= cfg_data;
				pmc_pkg::CFG_GYRO_OFFSET_Y:        off_y_q <= cfg_data;
				pmc_pkg::CFG_GYRO_OFFSET_Z:        off_z_q <= cfg_data;
				pmc_pkg::CFG_ARM_THRESHOLD:        thr_q   <= cfg_data;
				pmc_pkg::CFG_POST_TRIGGER_SAMPLES: post_q  <= cfg_data[pmc_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// offset correction, one sign-extended add per axis
	assign gx = {gyro_x[pmc_pkg::RAW_W-1], gyro_x} + {off_x_q[pmc_pkg::RAW_W-1], off_x_q};
	assign gy = {gyro_y[pmc_pkg::RAW_W-1], gyro_y} + {off_y_q[pmc_pkg::RAW_W-1], off_y_q};
	assign gz = {gyro_z[pmc_pkg::RAW_W-1], gyro_z} + {off_z_q[pmc_pkg::RAW_W-1], off_z_q};

	// magnitudes, the most negative value gives its true size unsigned
	assign mag_x   = gx[pmc_pkg::GYR_W-1] ? -gx : gx;
	assign mag_y   = gy[pmc_pkg::GYR_W-1] ? -gy : gy;
	assign mag_z   = gz[pmc_pkg::GYR_W-1] ? -gz : gz;
	assign thr_ext = {1'b0, thr_q};
	assign trig    = (mag_x > thr_ext) || (mag_y > thr_ext) || (mag_z > thr_ext);

	// post-trigger count saturates and never wraps
	assign cnt_next  = (cnt_q == pmc_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign slot_next = (slot_q == LAST_ADDR) ? '0 : slot_q + 1'b1;

	always_comb begin
		sts          = '0;
		sts.emit     = armed_q && (cnt_next >= post_q);
		sts.last_out = last_of_window;
	end

	// sample update: ring slot, arming and counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			armed_q  <= 1'b0;
			cnt_q    <= '0;
			valid_q  <= '0;
			rd_ptr_q <= '0;
			pos_q    <= '0;
		end else begin
			if (cmd.sample_we) begin
				slot_q          <= slot_next;
				valid_q[slot_q] <= 1'b1;
				if (!armed_q) begin
					if (trig) begin
						armed_q <= 1'b1;
						cnt_q   <= '0;
					end
				end else if (sts.emit) begin
					armed_q  <= 1'b0;
					cnt_q    <= '0;
					rd_ptr_q <= slot_next;
					pos_q    <= '0;
				end else begin
					cnt_q <= cnt_next;
				end
			end
			if (cmd.rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (cmd.load_out) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// entry valid flag follows the registered ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else if (cmd.rd_en) begin
			entry_valid_s1 <= valid_q[rd_ptr_q];
		end
	end

	assign wr_entry = {accel_x, accel_y, accel_z, gx, gy, gz};

	pmc_ram #(
		.WIDTH (pmc_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.sample_we),
		.waddr (slot_q),
		.wdata (wr_entry),
		.re    (cmd.rd_en),
		.raddr (rd_ptr_q),
		.rdata (rd_entry)
	);

	// slots never written read as zero
	assign out_entry = entry_valid_s1 ? rd_entry : '0;

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			{win_accel_x, win_accel_y, win_accel_z,
				win_gyro_x, win_gyro_y, win_gyro_z} <= out_entry;
			window_position <= pmc_pkg::POS_W'(pos_q);
			last_of_window  <= (pos_q == LAST_ADDR);
		end
	end

endmodule

@@ design/pretrigger_motion_capture.sv @@
// Pretrigger motion capture: each accepted six-axis sample has the configured offsets added
// to its gyro axes and is written into a ring of the last WINDOW_DEPTH samples held in one
// RAM; slots not yet written since reset read as zero through per-slot valid flags, so
// no clearing pass follows reset. While idle, a corrected gyro axis of magnitude strictly
// above the arming threshold arms capture; post_trigger_samples samples later (at least one)
// the whole window leaves on the output channel oldest first, window_position counting from 0
// and last_of_window marking the newest sample. A sample that completes a window is followed
// by the readout of every entry, each passing through the READ state (registered read of the
// sample RAM), the LOAD state (output register) and the OUT state until out_ready is high;
// in_ready stays low until the last entry has been transferred. Configuration is written
// through cfg_we, cfg_index, cfg_data.
module pretrigger_motion_capture #(
	parameter int WINDOW_DEPTH = 60
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic        [pmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [pmc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pmc_pkg::RAW_W-1:0]      accel_x,
	input  logic signed [pmc_pkg::RAW_W-1:0]      accel_y,
	input  logic signed [pmc_pkg::RAW_W-1:0]      accel_z,
	input  logic signed [pmc_pkg::RAW_W-1:0]      gyro_x,
	input  logic signed [pmc_pkg::RAW_W-1:0]      gyro_y,
	input  logic signed [pmc_pkg::RAW_W-1:0]      gyro_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pmc_pkg::ACC_W-1:0]      win_accel_x,
	output logic signed [pmc_pkg::ACC_W-1:0]      win_accel_y,
	output logic signed [pmc_pkg::ACC_W-1:0]      win_accel_z,
	output logic signed [pmc_pkg::GYR_W-1:0]      win_gyro_x,
	output logic signed [pmc_pkg::GYR_W-1:0]      win_gyro_y,
	output logic signed [pmc_pkg::GYR_W-1:0]      win_gyro_z,
	output logic        [pmc_pkg::POS_W-1:0]      window_position,
	output logic                                  last_of_window
);

	pmc_pkg::pmc_cmd_t cmd;
	pmc_pkg::pmc_sts_t sts;

	// controller
	pmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// datapath
	pmc_dp #(
		.DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.accel_x         (accel_x),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.gyro_x          (gyro_x),
		.gyro_y          (gyro_y),
		.gyro_z          (gyro_z),
		.sts             (sts),
		.win_accel_x     (win_accel_x),
		.win_accel_y     (win_accel_y),
		.win_accel_z     (win_accel_z),
		.win_gyro_x      (win_gyro_x),
		.win_gyro_y      (win_gyro_y),
		.win_gyro_z      (win_gyro_z),
		.window_position (window_position),
		.last_of_window  (last_of_window)
	);

	// no sample is taken while a window is being read out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a window entry is pending");

	// the last marker sits on the newest position only
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_window ==
			(window_position == pmc_pkg::POS_W'(WINDOW_DEPTH - 1))))
		else $error("last marker and window position disagree");

	// after the last transfer the block takes samples again
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_window |=> in_ready)
		else $error("block not ready after the end of a window");

	// inside a window the next entry follows without taking samples
	a_mid_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_window |=> !in_ready && !out_valid)
		else $error("window readout broken off");

	// positions step by one through the window
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_window |=> ##2
			(window_position == $past(window_position, 3) + 1'b1))
		else $error("window position did not advance by one");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int WINDOW_DEPTH  = 60;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES   = 200;

	localparam int RAW_W      = pmc_pkg::RAW_W;
	localparam int ACC_W      = pmc_pkg::ACC_W;
	localparam int GYR_W      = pmc_pkg::GYR_W;
	localparam int THR_W      = pmc_pkg::THR_W;
	localparam int CNT_W      = pmc_pkg::CNT_W;
	localparam int POS_W      = pmc_pkg::POS_W;
	localparam int CFG_IDX_W  = pmc_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = pmc_pkg::CFG_DATA_W;

	typedef struct packed {
		logic signed [RAW_W-1:0] ax, ay, az, gx, gy, gz;
	} imu_sample_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] ax, ay, az;
		logic signed [GYR_W-1:0] gx, gy, gz;
		logic [POS_W-1:0]        pos;
		logic                    is_last;
	} window_row_t;

	typedef enum {SAMPLE_QUIET, SAMPLE_TRIGGER, SAMPLE_NOISE} sample_kind_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	imu_sample_t             sample_bus = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [ACC_W-1:0] win_accel_x, win_accel_y, win_accel_z;
	logic signed [GYR_W-1:0] win_gyro_x, win_gyro_y, win_gyro_z;
	logic [POS_W-1:0]        window_position;
	logic                    last_of_window;

	// register shadows, as last written
	logic signed [RAW_W-1:0] gyro_offset [3] = '{pmc_pkg::GYRO_OFFSET_X_RST,
		pmc_pkg::GYRO_OFFSET_Y_RST, pmc_pkg::GYRO_OFFSET_Z_RST};
	logic [THR_W-1:0]        arm_threshold        = pmc_pkg::ARM_THRESHOLD_RST;
	logic [CNT_W-1:0]        post_trigger_samples = pmc_pkg::POST_TRIGGER_SAMPLES_RST;

	// predicted capture state
	logic signed [ACC_W-1:0] ring_accel [WINDOW_DEPTH][3] = '{default: '0};
	logic signed [GYR_W-1:0] ring_gyro  [WINDOW_DEPTH][3] = '{default: '0};
	int unsigned             ring_slot      = 0;
	bit                      capture_armed  = 1'b0;
	int unsigned             since_trigger  = 0;

	imu_sample_t             samples_to_send [$];
	window_row_t             window_rows_due [$];
	int                      mismatch_count = 0;
	int                      rows_checked   = 0;
	int unsigned             send_idle_pct  = 0;
	int unsigned             recv_idle_pct  = 0;
	int                      phase_no       = 0;
	int                      hold_left      = 0;
	bit                      hold_taken     = 1'b0;
	int                      stall_cycles   = 0;

	pretrigger_motion_capture #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.accel_x         (sample_bus.ax),
		.accel_y         (sample_bus.ay),
		.accel_z         (sample_bus.az),
		.gyro_x          (sample_bus.gx),
		.gyro_y          (sample_bus.gy),
		.gyro_z          (sample_bus.gz),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.win_accel_x     (win_accel_x),
		.win_accel_y     (win_accel_y),
		.win_accel_z     (win_accel_z),
		.win_gyro_x      (win_gyro_x),
		.win_gyro_y      (win_gyro_y),
		.win_gyro_z      (win_gyro_z),
		.window_position (window_position),
		.last_of_window  (last_of_window)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// store one sample in the ring and queue the window it completes, if any
	task automatic predict_capture(input imu_sample_t s);
		logic signed [RAW_W-1:0] raw [3];
		logic signed [GYR_W-1:0] g [3];
		window_row_t             row;
		bit                      over;
		int unsigned             idx;
		raw[0] = s.gx;
		raw[1] = s.gy;
		raw[2] = s.gz;
		over = 1'b0;
		for (int k = 0; k < 3; k++) begin
			g[k] = GYR_W'(raw[k]) + GYR_W'(gyro_offset[k]);
			if ((g[k] < 0 ? -int'(g[k]) : int'(g[k])) > int'(arm_threshold))
				over = 1'b1;
			ring_gyro[ring_slot][k] = g[k];
		end
		ring_accel[ring_slot][0] = s.ax;
		ring_accel[ring_slot][1] = s.ay;
		ring_accel[ring_slot][2] = s.az;
		ring_slot = (ring_slot + 1) % WINDOW_DEPTH;

		// idle: arming test only, the trigger sample itself is not counted
		if (!capture_armed) begin
			if (over) begin
				capture_armed = 1'b1;
				since_trigger = 0;
			end
			return;
		end

		// armed: saturating count against the current post-trigger setting
		if (since_trigger < pmc_pkg::CNT_MAX)
			since_trigger++;
		if (since_trigger < post_trigger_samples)
			return;

		// whole ring, oldest first
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			idx = (ring_slot + i) % WINDOW_DEPTH;
			row.ax      = ring_accel[idx][0];
			row.ay      = ring_accel[idx][1];
			row.az      = ring_accel[idx][2];
			row.gx      = ring_gyro[idx][0];
			row.gy      = ring_gyro[idx][1];
			row.gz      = ring_gyro[idx][2];
			row.pos     = POS_W'(i);
			row.is_last = (i == WINDOW_DEPTH - 1);
			window_rows_due.push_back(row);
		end
		capture_armed = 1'b0;
		since_trigger = 0;
	endtask

	task automatic compare_field(input string name, input logic [GYR_W-1:0] got,
			input logic [GYR_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("row %0d %s: got %h, expected %h",
				rows_checked, name, got, want));
	endtask

	task automatic check_row();
		window_row_t got;
		window_row_t want;
		got = '{win_accel_x, win_accel_y, win_accel_z, win_gyro_x, win_gyro_y,
			win_gyro_z, window_position, last_of_window};
		if (window_rows_due.size() == 0) begin
			report_mismatch($sformatf("window row at position %0d with none expected",
				window_position));
			return;
		end
		want = window_rows_due.pop_front();
		compare_field("win_accel_x", GYR_W'(got.ax), GYR_W'(want.ax));
		compare_field("win_accel_y", GYR_W'(got.ay), GYR_W'(want.ay));
		compare_field("win_accel_z", GYR_W'(got.az), GYR_W'(want.az));
		compare_field("win_gyro_x", got.gx, want.gx);
		compare_field("win_gyro_y", got.gy, want.gy);
		compare_field("win_gyro_z", got.gz, want.gz);
		compare_field("window_position", GYR_W'(got.pos), GYR_W'(want.pos));
		compare_field("last_of_window", GYR_W'(got.is_last), GYR_W'(want.is_last));
		rows_checked++;
	endtask

	// gyro word whose corrected value stays within the threshold where possible
	function automatic logic signed [RAW_W-1:0] quiet_axis(input int off);
		int target;
		int raw;
		target = int'($urandom_range(arm_threshold, 0));
		if ($urandom_range(1, 0) != 0)
			target = -target;
		raw = target - off;
		if (raw > 32767)
			raw = 32767;
		else if (raw < -32768)
			raw = -32768;
		return RAW_W'(raw);
	endfunction

	function automatic imu_sample_t random_sample(input sample_kind_t kind);
		logic signed [RAW_W-1:0] g [3];
		int                      axis;
		for (int k = 0; k < 3; k++)
			g[k] = (kind == SAMPLE_NOISE) ? RAW_W'($urandom) :
				quiet_axis(int'(gyro_offset[k]));
		if (kind == SAMPLE_TRIGGER) begin
			axis = $urandom_range(2, 0);
			g[axis] = (gyro_offset[axis] < 0) ? 16'sh8000 : 16'sh7fff;
		end
		return '{RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom), g[0], g[1], g[2]};
	endfunction

	task automatic queue_sample(input int ax, input int ay, input int az,
			input int gx, input int gy, input int gz);
		samples_to_send.push_back('{RAW_W'(ax), RAW_W'(ay), RAW_W'(az),
			RAW_W'(gx), RAW_W'(gy), RAW_W'(gz)});
	endtask

	// mostly quiet samples with the odd trigger, plus some full-range noise
	task automatic queue_random(input int count);
		int unsigned  pick;
		sample_kind_t kind;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99, 0);
			if (pick < 65)
				kind = SAMPLE_QUIET;
			else if (pick < 80)
				kind = SAMPLE_TRIGGER;
			else
				kind = SAMPLE_NOISE;
			samples_to_send.push_back(random_sample(kind));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= CFG_DATA_W'(value);
		case (index)
			pmc_pkg::CFG_GYRO_OFFSET_X:        gyro_offset[0] = RAW_W'(value);
			pmc_pkg::CFG_GYRO_OFFSET_Y:        gyro_offset[1] = RAW_W'(value);
			pmc_pkg::CFG_GYRO_OFFSET_Z:        gyro_offset[2] = RAW_W'(value);
			pmc_pkg::CFG_ARM_THRESHOLD:        arm_threshold = THR_W'(value);
			pmc_pkg::CFG_POST_TRIGGER_SAMPLES: post_trigger_samples = CNT_W'(value);
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// all samples transferred, every window row seen, block settled
	task automatic wait_until_idle();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || window_rows_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sample driver: a sample stays on the bus until its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_capture(sample_bus);
			if (!in_valid || in_ready) begin
				if (samples_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					sample_bus <= samples_to_send.pop_front();
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// window monitor: checks each row transfer, one long hold-off in phase 2
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_row();
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_taken && phase_no == 2 && out_valid) begin
				hold_taken <= 1'b1;
				hold_left  <= HOLD_CYCLES;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("pretrigger_motion_capture test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// stimulus and phase sequencing
	initial begin
		send_idle_pct = 6;
		recv_idle_pct = 67;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: threshold boundary, then a trigger; window shows unwritten slots
		phase_no = 0;
		queue_sample(32767, 32767, 32767, 0, 0, 0);
		queue_sample(-32768, -32768, -32768, -478, -100, -20);
		queue_sample(0, 0, 0, 7522, 0, 0);
		queue_sample(1, -1, 0, 0, -8101, 0);
		queue_sample(-1, 1, 21845, 32767, 0, 0);
		queue_sample(1, -1, -21846, -32768, -32768, -32768);
		queue_random(50);
		samples_to_send.push_back(random_sample(SAMPLE_TRIGGER));
		wait_until_idle();

		// extreme offsets, top threshold, post count of zero (changed while armed)
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_X, -32768);
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_Y, 32767);
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_Z, 0);
		write_reg(pmc_pkg::CFG_ARM_THRESHOLD, 65535);
		write_reg(pmc_pkg::CFG_POST_TRIGGER_SAMPLES, 0);
		end_writes();
		phase_no = 1;
		queue_sample(100, -100, 0, 32767, -32768, 0);
		queue_sample(0, 0, 0, 0, 32767, 0);
		queue_sample(-32768, 32767, -32768, -32768, 0, 0);
		queue_sample(32767, -32768, 32767, 32767, -32768, 0);
		queue_sample(0, 0, 0, -32768, 0, 0);
		queue_random(10);
		samples_to_send.push_back(random_sample(SAMPLE_TRIGGER));
		wait_until_idle();

		// zero threshold, post count of one: emission step must not re-arm
		send_idle_pct = 67;
		recv_idle_pct = 6;
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_X, 32767);
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_Y, -1);
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_Z, 1234);
		write_reg(pmc_pkg::CFG_ARM_THRESHOLD, 0);
		write_reg(pmc_pkg::CFG_POST_TRIGGER_SAMPLES, 1);
		end_writes();
		phase_no = 2;
		queue_sample(1, -1, 21845, -32767, 1, -1234);
		queue_sample(-2, 2, -21846, 0, 0, 0);
		queue_sample(3, -3, 0, -32768, 32767, 32767);
		queue_sample(-4, 4, 0, -32767, 1, -1234);
		queue_sample(5, -5, 0, 32767, -32768, -32768);
		queue_sample(-6, 6, 0, -32767, 1, -1234);
		queue_random(18);
		samples_to_send.push_back(random_sample(SAMPLE_TRIGGER));
		wait_until_idle();

		// post count beyond the usual range: the counter saturates
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_X, 0);
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_Y, 0);
		write_reg(pmc_pkg::CFG_GYRO_OFFSET_Z, 0);
		write_reg(pmc_pkg::CFG_ARM_THRESHOLD, 20000);
		write_reg(pmc_pkg::CFG_POST_TRIGGER_SAMPLES, 127);
		end_writes();
		phase_no = 3;
		queue_sample(0, 0, 0, 20001, 0, 0);
		queue_sample(0, 0, 0, 0, 0, -20000);
		queue_random(130);
		wait_until_idle();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (window_rows_due.size() != 0)
			report_mismatch($sformatf("%0d window rows never arrived", window_rows_due.size()));
		if (mismatch_count == 0)
			$display("pretrigger_motion_capture test passed");
		else
			$display("pretrigger_motion_capture test failed");
		$finish;
	end

endmodule
